[hw/rtl/wdm_pkg.sv]
// shared codes and types for the watchdog monitor bank
`timescale 1ns / 1ps

package wdm_pkg;

   // command codes on req_func
   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_REGISTER = 3'd1;
   localparam logic [2:0] FUNC_START    = 3'd2;
   localparam logic [2:0] FUNC_STOP     = 3'd3;
   localparam logic [2:0] FUNC_FEED     = 3'd4;
   localparam logic [2:0] FUNC_QUERY    = 3'd5;

   // per-channel status codes
   localparam logic [1:0] ST_COUNTING = 2'd0;
   localparam logic [1:0] ST_FEED     = 2'd1;
   localparam logic [1:0] ST_EXPIRED  = 2'd2;

   // what the update logic reports for one entry
   typedef struct packed {
      logic       wr_en;
      logic       hit;
      logic       running;
      logic [1:0] status;
      logic       registered;
   } upd_type;

endpackage

[hw/rtl/wdm_mem.sv]
// channel entry memory with registered read and per-entry valid bits
`timescale 1ns / 1ps

module wdm_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 68,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // an entry never written reads as the cleared entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/wdm_update.sv]
// next-entry logic for one channel under one command
`timescale 1ns / 1ps

module wdm_update #(
   parameter int CW = 32
) (
   input  logic [2:0]     func,
   input  logic           ok,
   input  logic [CW-1:0]  cmd_timeout,
   input  logic           cmd_enable,
   input  logic           cur_reg,
   input  logic           cur_en,
   input  logic [1:0]     cur_state,
   input  logic [CW-1:0]  cur_count,
   input  logic [CW-1:0]  cur_timeout,
   output logic           nxt_reg,
   output logic           nxt_en,
   output logic [1:0]     nxt_state,
   output logic [CW-1:0]  nxt_count,
   output logic [CW-1:0]  nxt_timeout,
   output wdm_pkg::upd_type upd
);

   logic [CW-1:0] inc_count;

   assign inc_count = cur_count + CW'(1);

   always_comb begin
      nxt_reg        = cur_reg;
      nxt_en         = cur_en;
      nxt_state      = cur_state;
      nxt_count      = cur_count;
      nxt_timeout    = cur_timeout;
      upd            = '0;
      case (func)
         wdm_pkg::FUNC_TICK: begin
            if (cur_reg && cur_en) begin
               if (cur_state == wdm_pkg::ST_COUNTING) begin
                  upd.wr_en = 1'b1;
                  if (inc_count >= cur_timeout) begin
                     nxt_count = '0;
                     nxt_state = wdm_pkg::ST_EXPIRED;
                     upd.hit   = 1'b1;
                  end else begin
                     nxt_count = inc_count;
                  end
               end else if (cur_state == wdm_pkg::ST_FEED) begin
                  upd.wr_en = 1'b1;
                  nxt_count = '0;
                  nxt_state = wdm_pkg::ST_COUNTING;
               end
            end
         end
         wdm_pkg::FUNC_REGISTER: begin
            if (ok) begin
               upd.wr_en   = 1'b1;
               nxt_reg     = 1'b1;
               nxt_en      = cmd_enable;
               nxt_state   = wdm_pkg::ST_COUNTING;
               nxt_count   = '0;
               nxt_timeout = cmd_timeout;
            end
         end
         wdm_pkg::FUNC_START, wdm_pkg::FUNC_STOP: begin
            if (ok && cur_reg) begin
               upd.wr_en = 1'b1;
               nxt_en    = (func == wdm_pkg::FUNC_START);
               nxt_state = wdm_pkg::ST_COUNTING;
               nxt_count = '0;
            end
         end
         wdm_pkg::FUNC_FEED: begin
            if (ok && cur_reg) begin
               upd.wr_en = 1'b1;
               nxt_state = wdm_pkg::ST_FEED;
            end
         end
         wdm_pkg::FUNC_QUERY: begin
            if (ok) begin
               upd.running    = cur_en;
               upd.status     = cur_state;
               upd.registered = cur_reg;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/watchdog_monitor_bank_top.sv]
// watchdog monitor bank top level: command sequencer around the entry memory
`timescale 1ns / 1ps

// Usage:
//   A command is taken on a rising edge with start high and busy low; its
//   fields are req_func, req_channel, req_timeout_ticks and
//   req_enable_at_register. Every command gives exactly one response beat,
//   shown for one cycle with rsp_valid high; the receiver cannot stall it.
//   All channel state (registered, enable, status, count, timeout) sits in
//   one entry per channel of a memory with a registered read.
//   Register, start, stop, feed, query and unused codes read the addressed
//   entry; register and, for a registered channel, start, stop and feed
//   write the updated entry back. A tick sweeps the entries, reading
//   entry i+1 on the single memory read port while entry i is updated
//   and, where it changes, written back. busy is high from accept until the
//   response cycle, so a new command may be accepted in that cycle.
//   Reset clears the per-entry valid bits at once, so every channel reads
//   as unregistered with zero count and timeout; no clearing pass is needed.

module watchdog_monitor_bank_top #(
   parameter int NUM_CHANNELS = 16,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_timeout_ticks,
   input  logic        req_enable_at_register,
   output logic        rsp_valid,
   output logic [15:0] rsp_expired_mask,
   output logic        rsp_running,
   output logic [1:0]  rsp_channel_status,
   output logic        rsp_is_registered
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW = COUNT_WIDTH;
   localparam int EW = 4 + 2 * CW;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CHANNELS - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SINGLE = 2'd1;
   localparam logic [1:0] S_SWEEP  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [2:0]    func_ff, func_in;
   logic          ok_ff, ok_in;
   logic [CW-1:0] tmo_ff, tmo_in;
   logic          en_ff, en_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [15:0]   mask_ff, mask_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_mask_ff, rsp_mask_in;
   logic          rsp_running_ff, rsp_running_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_reg_ff, rsp_reg_in;

   logic          accept;
   logic          req_ok;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          wr_en;
   logic [EW-1:0] wr_data;

   logic          nxt_reg, nxt_en;
   logic [1:0]    nxt_state;
   logic [CW-1:0] nxt_count, nxt_timeout;
   wdm_pkg::upd_type upd;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign req_ok = ({1'b0, req_channel} < 5'(NUM_CHANNELS));

   // entry layout: registered, enable, status, count, timeout
   wdm_update #(
      .CW(CW)
   ) u_update (
      .func        (func_ff),
      .ok          (ok_ff),
      .cmd_timeout (tmo_ff),
      .cmd_enable  (en_ff),
      .cur_reg     (rd_data[EW-1]),
      .cur_en      (rd_data[EW-2]),
      .cur_state   (rd_data[EW-3:EW-4]),
      .cur_count   (rd_data[2*CW-1:CW]),
      .cur_timeout (rd_data[CW-1:0]),
      .nxt_reg     (nxt_reg),
      .nxt_en      (nxt_en),
      .nxt_state   (nxt_state),
      .nxt_count   (nxt_count),
      .nxt_timeout (nxt_timeout),
      .upd         (upd)
   );

   assign wr_data = {nxt_reg, nxt_en, nxt_state, nxt_count, nxt_timeout};
   assign wr_en   = (state_ff != S_IDLE) && upd.wr_en;

   wdm_mem #(
      .DEPTH(NUM_CHANNELS),
      .WIDTH(EW),
      .AW   (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      ok_in          = ok_ff;
      tmo_in         = tmo_ff;
      en_in          = en_ff;
      idx_in         = idx_ff;
      mask_in        = mask_ff;
      rsp_valid_in   = 1'b0;
      rsp_mask_in    = '0;
      rsp_running_in = 1'b0;
      rsp_status_in  = '0;
      rsp_reg_in     = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = idx_ff + AW'(1);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_func;
               ok_in   = req_ok;
               tmo_in  = req_timeout_ticks[CW-1:0];
               en_in   = req_enable_at_register;
               mask_in = '0;
               rd_en   = 1'b1;
               if (req_func == wdm_pkg::FUNC_TICK) begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = S_SWEEP;
               end else begin
                  idx_in   = req_channel[AW-1:0];
                  rd_addr  = req_channel[AW-1:0];
                  state_in = S_SINGLE;
               end
            end
         end
         S_SINGLE: begin
            rsp_valid_in   = 1'b1;
            rsp_running_in = upd.running;
            rsp_status_in  = upd.status;
            rsp_reg_in     = upd.registered;
            state_in       = S_IDLE;
         end
         S_SWEEP: begin
            mask_in = mask_ff | (16'(upd.hit) << idx_ff);
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_in;
               state_in     = S_IDLE;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      ok_ff          <= ok_in;
      tmo_ff         <= tmo_in;
      en_ff          <= en_in;
      idx_ff         <= idx_in;
      mask_ff        <= mask_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_running_ff <= rsp_running_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_reg_ff     <= rsp_reg_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_expired_mask   = rsp_mask_ff;
   assign rsp_running        = rsp_running_ff;
   assign rsp_channel_status = rsp_status_ff;
   assign rsp_is_registered  = rsp_reg_ff;

endmodule

[tb/sv/tb_watchdog_monitor_bank_top.sv]
// self-checking testbench for the watchdog monitor bank command interface
`timescale 1ns / 1ps

module tb_watchdog_monitor_bank_top;

   localparam int          NUM_CH       = 16;
   localparam int          LIMIT_CYCLES = 200000;
   localparam int          RANDOM_CMDS  = 800;
   localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_B = 3'd7;

   typedef struct {
      logic [15:0] mask;
      logic        running;
      logic [1:0]  status;
      logic        registered;
   } wdm_reply_type;

   // shadow copy of the channel table plus the replies still owed by the block
   class watchdog_shadow;
      logic          reg_flag [NUM_CH];
      logic          en_flag  [NUM_CH];
      logic [31:0]   count    [NUM_CH];
      logic [31:0]   limit    [NUM_CH];
      logic [1:0]    status   [NUM_CH];
      wdm_reply_type owed [$];
      int            errors;
      int            n_cmds;
      int            n_ticks;
      int            n_expiries;
      int            n_queries;

      function new();
         for (int c = 0; c < NUM_CH; c++) begin
            reg_flag[c] = 1'b0;
            en_flag[c]  = 1'b0;
            count[c]    = '0;
            limit[c]    = '0;
            status[c]   = wdm_pkg::ST_COUNTING;
         end
         errors     = 0;
         n_cmds     = 0;
         n_ticks    = 0;
         n_expiries = 0;
         n_queries  = 0;
      endfunction

      function void note_command(input logic [2:0] func, input logic [3:0] ch,
                                 input logic [31:0] tmo, input logic en);
         wdm_reply_type r;
         logic [31:0]   n;
         r = '{mask: '0, running: 1'b0, status: wdm_pkg::ST_COUNTING, registered: 1'b0};
         n_cmds++;
         case (func)
            wdm_pkg::FUNC_TICK: begin
               n_ticks++;
               for (int c = 0; c < NUM_CH; c++) begin
                  if (reg_flag[c] && en_flag[c]) begin
                     if (status[c] == wdm_pkg::ST_COUNTING) begin
                        n = count[c] + 32'd1;
                        if (n >= limit[c]) begin
                           n = '0;
                           status[c] = wdm_pkg::ST_EXPIRED;
                           r.mask[c] = 1'b1;
                           n_expiries++;
                        end
                        count[c] = n;
                     end else if (status[c] == wdm_pkg::ST_FEED) begin
                        count[c]  = '0;
                        status[c] = wdm_pkg::ST_COUNTING;
                     end
                  end
               end
            end
            wdm_pkg::FUNC_REGISTER: begin
               limit[ch]    = tmo;
               en_flag[ch]  = en;
               count[ch]    = '0;
               status[ch]   = wdm_pkg::ST_COUNTING;
               reg_flag[ch] = 1'b1;
            end
            wdm_pkg::FUNC_START, wdm_pkg::FUNC_STOP: begin
               if (reg_flag[ch]) begin
                  en_flag[ch] = (func == wdm_pkg::FUNC_START);
                  count[ch]   = '0;
                  status[ch]  = wdm_pkg::ST_COUNTING;
               end
            end
            wdm_pkg::FUNC_FEED: begin
               if (reg_flag[ch])
                  status[ch] = wdm_pkg::ST_FEED;
            end
            wdm_pkg::FUNC_QUERY: begin
               n_queries++;
               r.running    = en_flag[ch];
               r.status     = status[ch];
               r.registered = reg_flag[ch];
            end
            default: ;
         endcase
         owed.push_back(r);
      endfunction

      function void check_reply(input logic [15:0] mask, input logic running,
                                input logic [1:0] st, input logic registered);
         wdm_reply_type e;
         if (owed.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         e = owed.pop_front();
         if (mask !== e.mask) begin
            $error("rsp_expired_mask: expected %h, got %h", e.mask, mask);
            errors++;
         end
         if (running !== e.running) begin
            $error("rsp_running: expected %b, got %b", e.running, running);
            errors++;
         end
         if (st !== e.status) begin
            $error("rsp_channel_status: expected %0d, got %0d", e.status, st);
            errors++;
         end
         if (registered !== e.registered) begin
            $error("rsp_is_registered: expected %b, got %b", e.registered, registered);
            errors++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = wdm_pkg::FUNC_TICK;
   logic [3:0]  req_channel = '0;
   logic [31:0] req_timeout_ticks = '0;
   logic        req_enable_at_register = 1'b0;
   logic        rsp_valid;
   logic [15:0] rsp_expired_mask;
   logic        rsp_running;
   logic [1:0]  rsp_channel_status;
   logic        rsp_is_registered;

   watchdog_shadow shadow = new();
   int             cycles = 0;
   bit             no_idle = 1'b0;

   watchdog_monitor_bank_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_func               (req_func),
      .req_channel            (req_channel),
      .req_timeout_ticks      (req_timeout_ticks),
      .req_enable_at_register (req_enable_at_register),
      .rsp_valid              (rsp_valid),
      .rsp_expired_mask       (rsp_expired_mask),
      .rsp_running            (rsp_running),
      .rsp_channel_status     (rsp_channel_status),
      .rsp_is_registered      (rsp_is_registered)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         shadow.check_reply(rsp_expired_mask, rsp_running, rsp_channel_status,
                            rsp_is_registered);
   end

   // start is left high after a beat so back-to-back commands need no toggle
   task automatic send_cmd(input logic [2:0] f, input logic [3:0] ch,
                           input logic [31:0] tmo, input logic en);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                  <= 1'b1;
      req_func               <= f;
      req_channel            <= ch;
      req_timeout_ticks      <= tmo;
      req_enable_at_register <= en;
      do @(posedge clock); while (busy);
      shadow.note_command(f, ch, tmo, en);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int          r;
      logic [2:0]  f;
      logic [31:0] tmo;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_cmd(wdm_pkg::FUNC_QUERY,    4'd0,  $urandom, 1'b1);
      send_cmd(wdm_pkg::FUNC_START,    4'd3,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_FEED,     4'd3,  $urandom, 1'b1);
      send_cmd(wdm_pkg::FUNC_STOP,     4'd3,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_QUERY,    4'd3,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd15, $urandom, 1'b1);
      // zero timeout expires on the first counting tick
      send_cmd(wdm_pkg::FUNC_REGISTER, 4'd0,  32'd0, 1'b1);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_QUERY,    4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_FEED,     4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_QUERY,    4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd7,  $urandom, 1'b1);
      // disabled channel keeps a pending feed across ticks
      send_cmd(wdm_pkg::FUNC_REGISTER, 4'd15, 32'hFFFF_FFFF, 1'b0);
      send_cmd(wdm_pkg::FUNC_FEED,     4'd15, $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd15, $urandom, 1'b1);
      send_cmd(wdm_pkg::FUNC_QUERY,    4'd15, $urandom, 1'b1);
      send_cmd(wdm_pkg::FUNC_START,    4'd15, $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_REGISTER, 4'd1,  32'd2, 1'b1);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_TICK,     4'd0,  $urandom, 1'b0);
      send_cmd(wdm_pkg::FUNC_REGISTER, 4'd1,  32'h5A5A_A5A5, 1'b1);
      send_cmd(wdm_pkg::FUNC_STOP,     4'd0,  $urandom, 1'b1);
      send_cmd(FUNC_SPARE_A,           4'd15, 32'hFFFF_FFFF, 1'b1);
      send_cmd(FUNC_SPARE_B,           4'd0,  32'd0, 1'b0);

      for (int i = 0; i < RANDOM_CMDS; i++) begin
         no_idle = ((i / 100) % 3 == 1);
         if (i == RANDOM_CMDS / 2)
            drain();
         r = $urandom_range(0, 99);
         if (r < 35)      f = wdm_pkg::FUNC_TICK;
         else if (r < 47) f = wdm_pkg::FUNC_REGISTER;
         else if (r < 55) f = wdm_pkg::FUNC_START;
         else if (r < 61) f = wdm_pkg::FUNC_STOP;
         else if (r < 73) f = wdm_pkg::FUNC_FEED;
         else if (r < 93) f = wdm_pkg::FUNC_QUERY;
         else             f = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
         // mostly short timeouts so channels actually expire
         if (f == wdm_pkg::FUNC_REGISTER && $urandom_range(0, 4) != 0)
            tmo = $urandom_range(0, 8);
         else
            tmo = $urandom;
         send_cmd(f, 4'($urandom_range(0, NUM_CH - 1)), tmo, 1'($urandom_range(0, 1)));
      end
      drain();
      repeat (NUM_CH + 4) @(posedge clock);

      $display("ran %0d commands: %0d ticks with %0d channel expiries, %0d queries",
               shadow.n_cmds, shadow.n_ticks, shadow.n_expiries, shadow.n_queries);
      $display("gaps, back-to-back bursts and a full drain pause were exercised");
      if (shadow.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/wdm_pkg.sv
hw/rtl/wdm_mem.sv
hw/rtl/wdm_update.sv
hw/rtl/watchdog_monitor_bank_top.sv
tb/sv/tb_watchdog_monitor_bank_top.sv
